>>> sv/triangle_normal_to_colour_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_NORMAL_TO_COLOUR_TOP_MACROS_SVH
`define TRIANGLE_NORMAL_TO_COLOUR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// The condition holds at every clock edge outside reset.
`define ASSERT_COMB(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// The consequent holds in the cycle after the antecedent.
`define ASSERT_SEQ(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_COMB(label, clk, rst_n, cond, msg)
`define ASSERT_SEQ(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> sv/tn2c_pkg.sv
// ----------------------------------------------------------------------------
// tn2c_pkg
// Shared types and constants of the triangle normal colour pipeline.
// ----------------------------------------------------------------------------
package tn2c_pkg;
    typedef logic [7:0] t_byte;
    // 127.5 squared, times four: the scale of the byte comparison.
    localparam int BYTE_SCALE = 65025;
    localparam int BYTE_HALF  = 255;
    localparam int BYTE_BITS  = 8;
    // One set-up stage and one stage per result bit.
    localparam int SEARCH_STAGES = BYTE_BITS + 1;
    localparam t_byte BYTE_MID = 8'd127;
endpackage

>>> sv/tn2c_if.sv
// ----------------------------------------------------------------------------
// tn2c interfaces
// Valid/ready channels for triangle words and colour words.
// ----------------------------------------------------------------------------
interface tn2c_in_if #(parameter int COORD_BITS = 16);
    logic valid;
    logic ready;
    logic signed [COORD_BITS-1:0] vert0_x, vert0_y, vert0_z;
    logic signed [COORD_BITS-1:0] vert1_x, vert1_y, vert1_z;
    logic signed [COORD_BITS-1:0] vert2_x, vert2_y, vert2_z;
    modport source (output valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
                    vert2_x, vert2_y, vert2_z, input ready);
    modport sink (input valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
                  vert2_x, vert2_y, vert2_z, output ready);
endinterface

interface tn2c_out_if;
    logic valid;
    logic ready;
    tn2c_pkg::t_byte normal_y_byte;
    tn2c_pkg::t_byte normal_x_byte;
    logic degenerate;
    modport source (output valid, normal_y_byte, normal_x_byte, degenerate, input ready);
    modport sink (input valid, normal_y_byte, normal_x_byte, degenerate, output ready);
endinterface

>>> sv/triangle_normal_to_colour_top.sv
// ----------------------------------------------------------------------------
// triangle_normal_to_colour_top
// Face normal of a triangle mapped to the Y and X bytes of a normal map.
// ----------------------------------------------------------------------------
//  Channel  Dir  Word
//  i_tri    in   three vertices, nine signed Q8.8 coordinates
//  o_nrm    out  normal_y_byte, normal_x_byte, degenerate
//
// One triangle word is taken in every cycle while the output is not held; each
// word passes through the cross product, squared length and byte search stages.
// The byte search decides one bit per stage, after a set-up stage.
// Reset (synchronous, active low) clears only the valid bits of the stages.
// When the output word is held by the sink the whole pipeline freezes, so no
// word is dropped or repeated; i_tri.ready falls in the same cycle.
// ----------------------------------------------------------------------------
`include "triangle_normal_to_colour_top_macros.svh"

module triangle_normal_to_colour_top #(
    parameter int COORD_BITS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    tn2c_in_if.sink i_tri,
    tn2c_out_if.source o_nrm
);
    localparam int CW  = COORD_BITS;
    localparam int NS  = tn2c_pkg::SEARCH_STAGES;

    logic w_en;
    logic w_cross_v, w_norm_v, w_y_v, w_x_v;
    logic signed [2*CW+2:0] w_cx, w_cy, w_cz;
    logic [4*CW+5:0]  w_len_sq;
    logic [4*CW+21:0] w_kx, w_ky;
    logic w_neg_x, w_neg_y, w_deg;
    tn2c_pkg::t_byte w_byte_y, w_byte_x;
    logic [NS-1:0] r_deg;

    // The pipeline advances whenever the output register is free or drained.
    assign w_en        = !w_y_v || o_nrm.ready;
    assign i_tri.ready = w_en;

    tn2c_cross #(.CW(CW)) u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_tri.valid),
        .i_v0x   (i_tri.vert0_x), .i_v0y (i_tri.vert0_y), .i_v0z (i_tri.vert0_z),
        .i_v1x   (i_tri.vert1_x), .i_v1y (i_tri.vert1_y), .i_v1z (i_tri.vert1_z),
        .i_v2x   (i_tri.vert2_x), .i_v2y (i_tri.vert2_y), .i_v2z (i_tri.vert2_z),
        .o_valid (w_cross_v),
        .o_cx    (w_cx), .o_cy (w_cy), .o_cz (w_cz)
    );

    tn2c_norm #(.CW(CW)) u_norm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_cross_v),
        .i_cx     (w_cx), .i_cy (w_cy), .i_cz (w_cz),
        .o_valid  (w_norm_v),
        .o_len_sq (w_len_sq),
        .o_kx     (w_kx),
        .o_ky     (w_ky),
        .o_neg_x  (w_neg_x),
        .o_neg_y  (w_neg_y),
        .o_deg    (w_deg)
    );

    tn2c_byte_search #(.CW(CW)) u_search_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_norm_v),
        .i_len_sq (w_len_sq),
        .i_k      (w_ky),
        .i_neg    (w_neg_y),
        .o_valid  (w_y_v),
        .o_byte   (w_byte_y)
    );

    tn2c_byte_search #(.CW(CW)) u_search_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_norm_v),
        .i_len_sq (w_len_sq),
        .i_k      (w_kx),
        .i_neg    (w_neg_x),
        .o_valid  (w_x_v),
        .o_byte   (w_byte_x)
    );

    // The zero-length flag rides alongside the byte search.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_deg <= {r_deg[NS-2:0], w_deg};
        end
    end

    assign o_nrm.valid         = w_y_v;
    assign o_nrm.degenerate    = r_deg[NS-1];
    assign o_nrm.normal_y_byte = r_deg[NS-1] ? tn2c_pkg::BYTE_MID : w_byte_y;
    assign o_nrm.normal_x_byte = r_deg[NS-1] ? tn2c_pkg::BYTE_MID : w_byte_x;

    // Both byte searches run in lock step.
    `ASSERT_COMB(a_lanes_aligned, i_clk, i_rst_n, w_y_v == w_x_v, "byte lanes out of step")
    // A held output word freezes the search stages.
    `ASSERT_SEQ(a_hold_stable, i_clk, i_rst_n, o_nrm.valid && !o_nrm.ready,
                $stable(w_byte_y) && $stable(w_byte_x), "search moved during stall")
    // A valid flat triangle gives the mid byte; this checks the X channel.
    `ASSERT_COMB(a_deg_mid, i_clk, i_rst_n,
                 !o_nrm.valid || !o_nrm.degenerate || (o_nrm.normal_x_byte == tn2c_pkg::BYTE_MID),
                 "degenerate word without mid byte")
endmodule

>>> sv/tn2c_cross.sv
// ----------------------------------------------------------------------------
// tn2c_cross
// Edge vectors, partial products and cross product over three stages.
// ----------------------------------------------------------------------------
module tn2c_cross #(
    parameter int CW = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic signed [CW-1:0]       i_v0x, i_v0y, i_v0z,
    input  logic signed [CW-1:0]       i_v1x, i_v1y, i_v1z,
    input  logic signed [CW-1:0]       i_v2x, i_v2y, i_v2z,
    output logic                       o_valid,
    output logic signed [2*CW+2:0]     o_cx, o_cy, o_cz
);
    localparam int EW  = CW + 1;
    localparam int PW  = 2 * EW;
    localparam int CRW = PW + 1;

    logic [2:0] r_v;
    logic signed [EW-1:0]  r_e1x, r_e1y, r_e1z, r_e2x, r_e2y, r_e2z;
    logic signed [PW-1:0]  r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [CRW-1:0] r_cx, r_cy, r_cz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e1x <= EW'(i_v1x) - EW'(i_v0x);
            r_e1y <= EW'(i_v1y) - EW'(i_v0y);
            r_e1z <= EW'(i_v1z) - EW'(i_v0z);
            r_e2x <= EW'(i_v2x) - EW'(i_v0x);
            r_e2y <= EW'(i_v2y) - EW'(i_v0y);
            r_e2z <= EW'(i_v2z) - EW'(i_v0z);
            r_p0  <= PW'(r_e1y) * PW'(r_e2z);
            r_p1  <= PW'(r_e1z) * PW'(r_e2y);
            r_p2  <= PW'(r_e1z) * PW'(r_e2x);
            r_p3  <= PW'(r_e1x) * PW'(r_e2z);
            r_p4  <= PW'(r_e1x) * PW'(r_e2y);
            r_p5  <= PW'(r_e1y) * PW'(r_e2x);
            r_cx  <= CRW'(r_p0) - CRW'(r_p1);
            r_cy  <= CRW'(r_p2) - CRW'(r_p3);
            r_cz  <= CRW'(r_p4) - CRW'(r_p5);
        end
    end

    assign o_valid = r_v[2];
    assign o_cx = r_cx;
    assign o_cy = r_cy;
    assign o_cz = r_cz;
endmodule

>>> sv/tn2c_norm.sv
// ----------------------------------------------------------------------------
// tn2c_norm
// Squared length of the normal and the scaled component squares.
// ----------------------------------------------------------------------------
module tn2c_norm #(
    parameter int CW = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [2*CW+2:0]  i_cx, i_cy, i_cz,
    output logic                    o_valid,
    output logic [4*CW+5:0]         o_len_sq,
    output logic [4*CW+21:0]        o_kx, o_ky,
    output logic                    o_neg_x, o_neg_y,
    output logic                    o_deg
);
    localparam int CRW = 2 * CW + 3;
    localparam int SW  = 2 * CRW;
    localparam int KW  = SW + 16;

    logic [1:0] r_v;
    logic signed [SW-1:0] w_sqx, w_sqy, w_sqz;
    logic [SW-1:0] r_sqx, r_sqy, r_sqz, w_sum;
    logic r_nx0, r_ny0, r_nx1, r_ny1, r_deg;
    logic [SW-1:0] r_len_sq;
    logic [KW-1:0] r_kx, r_ky;

    assign w_sqx = i_cx * i_cx;
    assign w_sqy = i_cy * i_cy;
    assign w_sqz = i_cz * i_cz;
    assign w_sum = r_sqx + r_sqy + r_sqz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sqx    <= w_sqx;
            r_sqy    <= w_sqy;
            r_sqz    <= w_sqz;
            r_nx0    <= i_cx[CRW-1];
            r_ny0    <= i_cy[CRW-1];
            r_len_sq <= w_sum;
            r_kx     <= KW'(r_sqx) * KW'(tn2c_pkg::BYTE_SCALE);
            r_ky     <= KW'(r_sqy) * KW'(tn2c_pkg::BYTE_SCALE);
            r_nx1    <= r_nx0;
            r_ny1    <= r_ny0;
            r_deg    <= (w_sum == '0);
        end
    end

    assign o_valid  = r_v[1];
    assign o_len_sq = r_len_sq;
    assign o_kx     = r_kx;
    assign o_ky     = r_ky;
    assign o_neg_x  = r_nx1;
    assign o_neg_y  = r_ny1;
    assign o_deg    = r_deg;
endmodule

>>> sv/tn2c_byte_search.sv
// ----------------------------------------------------------------------------
// tn2c_byte_search
// Finds the colour byte one bit per stage, keeping d*d*s and d*s by adds.
// ----------------------------------------------------------------------------
module tn2c_byte_search #(
    parameter int CW = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [4*CW+5:0]    i_len_sq,
    input  logic [4*CW+21:0]   i_k,
    input  logic               i_neg,
    output logic               o_valid,
    output tn2c_pkg::t_byte    o_byte
);
    localparam int SW = 4 * CW + 6;
    localparam int KW = SW + 16;
    localparam int AW = SW + 20;
    localparam int NS = tn2c_pkg::SEARCH_STAGES;

    // With d = 2b - 255, stage t tries the next bit of b and keeps
    // A = d*d*s and B = d*s so that each trial needs only shifted adds.
    logic signed [AW-1:0] w_s_ext;
    logic [NS-1:0]        r_v;
    logic signed [AW-1:0] r_a [NS];
    logic signed [AW-1:0] r_b [NS];
    logic signed [AW-1:0] r_s [NS];
    logic signed [AW-1:0] r_k [NS];
    logic                 r_neg [NS];
    tn2c_pkg::t_byte      r_byte [NS];

    assign w_s_ext = signed'(AW'(i_len_sq));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a[0]    <= w_s_ext * AW'(tn2c_pkg::BYTE_SCALE);
            r_b[0]    <= -(w_s_ext * AW'(tn2c_pkg::BYTE_HALF));
            r_s[0]    <= w_s_ext;
            r_k[0]    <= signed'(AW'(i_k));
            r_neg[0]  <= i_neg;
            r_byte[0] <= '0;
        end
    end

    for (genvar t = 1; t < NS; t++) begin : g_stage
        localparam int J = NS - 1 - t;
        tn2c_pkg::t_byte      w_trial;
        logic signed [AW-1:0] w_a, w_b;
        logic                 w_fit;

        assign w_trial = r_byte[t-1] | tn2c_pkg::t_byte'(1 << J);
        assign w_a = r_a[t-1] + (r_b[t-1] <<< (J + 2)) + (r_s[t-1] <<< (2 * J + 2));
        assign w_b = r_b[t-1] + (r_s[t-1] <<< (J + 1));
        // Upper half of the range means a positive d.
        assign w_fit = w_trial[tn2c_pkg::BYTE_BITS-1]
                     ? (!r_neg[t-1] && (w_a <= r_k[t-1]))
                     : (!r_neg[t-1] || (w_a >= r_k[t-1]));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s[t]   <= r_s[t-1];
                r_k[t]   <= r_k[t-1];
                r_neg[t] <= r_neg[t-1];
                if (w_fit) begin
                    r_a[t]    <= w_a;
                    r_b[t]    <= w_b;
                    r_byte[t] <= w_trial;
                end else begin
                    r_a[t]    <= r_a[t-1];
                    r_b[t]    <= r_b[t-1];
                    r_byte[t] <= r_byte[t-1];
                end
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_byte  = r_byte[NS-1];
endmodule
